/* rtl/sfm_pkg.sv */
// Shared constants, types and code values for the substring first-match search.
package sfm_pkg;

	localparam int PATTERN_MAX   = 16;
	localparam int POSITION_BITS = 16;
	localparam int BYTE_W        = 8;
	localparam int WORD_W        = 64;
	localparam int LEN_W         = 5;
	localparam int INDEX_W       = 16;
	localparam int STATUS_W      = 2;
	localparam int REG_IDX_W     = 2;
	localparam int CELL_IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int SUM_W         = (POSITION_BITS + 1 > INDEX_W) ? POSITION_BITS + 1 : INDEX_W;

	typedef logic [BYTE_W-1:0]        byte_t;
	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LEN_W-1:0]         len_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

	localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};
	localparam len_t LEN_MAX = LEN_W'(PATTERN_MAX);

endpackage

/* rtl/substring_first_match.sv */
// Top level of the streaming first-match substring search.
//
// The block takes one text byte per cycle and keeps a row of cells, one per pattern byte, in
// which cell k holds whether the newest k+1 bytes equal the first k+1 pattern bytes. A result
// is loaded into the output register at the transfer of the byte that completes the
// first occurrence, or of the final byte when there is none; at most one result per text.
// Input is stalled only while a result waits in the output register and is not being taken.
// A pattern length above sixteen acts as sixteen; positions saturate at their maximum.
module substring_first_match (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [sfm_pkg::WORD_W-1:0]         cfg_data,
	input  logic                               text_valid,
	output logic                               text_stall,
	input  logic [sfm_pkg::BYTE_W-1:0]         text_byte,
	input  logic                               end_of_text,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [sfm_pkg::STATUS_W-1:0]       status,
	output logic [sfm_pkg::INDEX_W-1:0]        match_index,
	output logic [sfm_pkg::LEN_W-1:0]          match_length,
	output logic                               last
);
	import sfm_pkg::*;

	logic [WORD_W-1:0]       pat_lo_q;
	logic [WORD_W-1:0]       pat_hi_q;
	len_t                    len_q;
	logic [2*WORD_W-1:0]     pattern;
	len_t                    len_eff;
	logic [PATTERN_MAX-1:0]  cell_hit;
	logic [PATTERN_MAX-1:0]  cell_hit_q;
	logic [PATTERN_MAX-1:0]  cell_prev;
	logic [CELL_IDX_W-1:0]   sel;
	pos_t                    pos_q;
	logic                    reported_q;
	logic                    accept;
	logic                    hit;
	logic                    found;
	logic                    result;
	logic [SUM_W-1:0]        count_now;
	logic [SUM_W-1:0]        start_pos;
	logic                    out_valid_q;
	status_t                 status_q;
	logic [INDEX_W-1:0]      index_q;
	len_t                    length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LO:  pat_lo_q <= cfg_data;
				REG_PAT_HI:  pat_hi_q <= cfg_data;
				REG_PAT_LEN: len_q    <= cfg_data[LEN_W-1:0];
				default:     ;
			endcase
		end
	end

	assign pattern = {pat_hi_q, pat_lo_q};
	assign len_eff = (len_q > LEN_MAX) ? LEN_MAX : len_q;
	assign accept  = text_valid && !text_stall;
	assign text_stall = out_valid_q && result_stall;

	assign cell_prev = {cell_hit_q[PATTERN_MAX-2:0], 1'b1};

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		sfm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (accept),
			.restart      (end_of_text),
			.text_byte    (text_byte),
			.pattern_byte (pattern[k*BYTE_W +: BYTE_W]),
			.prev_q       (cell_prev[k]),
			.hit          (cell_hit[k]),
			.hit_q        (cell_hit_q[k])
		);
	end

	assign sel       = CELL_IDX_W'(len_eff - LEN_W'(1));
	assign hit       = (len_eff != '0) && cell_hit[sel];
	assign found     = !reported_q && hit;
	assign result    = found || (end_of_text && !reported_q);
	assign count_now = SUM_W'(pos_q) + SUM_W'(1);
	assign start_pos = count_now - SUM_W'(len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
				reported_q <= reported_q || found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && result) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && result) begin
			if (found) begin
				status_q <= ST_FOUND;
				index_q  <= start_pos[INDEX_W-1:0];
				length_q <= len_eff;
			end else begin
				status_q <= (SUM_W'(len_eff) > count_now) ? ST_TOO_LONG : ST_NOT_FOUND;
				index_q  <= '0;
				length_q <= '0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign match_index  = index_q;
	assign match_length = length_q;
	assign last         = 1'b1;

endmodule

/* rtl/sfm_cell.sv */
// One cell of the match chain: tracks a partial match that ends at the newest byte.
module sfm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          restart,
	input  sfm_pkg::byte_t text_byte,
	input  sfm_pkg::byte_t pattern_byte,
	input  logic          prev_q,
	output logic          hit,
	output logic          hit_q
);
	import sfm_pkg::*;

	assign hit = prev_q && (text_byte == pattern_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (advance) begin
			hit_q <= restart ? 1'b0 : hit;
		end
	end

endmodule

/* dv/tb.sv */
// Self-checking testbench for the streaming first-match substring search, with a byte predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfm_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] index;
		len_t               length;
	} outcome_t;

	typedef struct packed {
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		len_t              len;
	} pattern_cfg_t;

	typedef struct packed {
		logic [1:0] setting;
		byte_t      value;
		logic       eot;
		logic       typed;
		outcome_t   want;
	} directed_step_t;

	localparam int DRAIN_CYCLES    = 6;
	localparam int DIRECTED_COUNT  = 25;
	localparam int RANDOM_PHASES   = 10;
	localparam int PHASE_BYTES     = 175;
	localparam int QUIET_PHASE     = 4;
	localparam int PAUSE_PHASE     = 7;

	localparam outcome_t NO_OUTCOME = '{ST_FOUND, 16'd0, 5'd0};

	localparam pattern_cfg_t DIRECTED_CFG [4] = '{
		'{64'h0, 64'h0, 5'd0},
		'{64'h0000_0000_0043_4241, {WORD_W{1'b1}}, 5'd3},
		'{64'h0, 64'h0, 5'd1},
		'{{WORD_W{1'b1}}, {WORD_W{1'b1}}, 5'd31}
	};

	localparam directed_step_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
		'{2'd0, 8'h00, 1'b1, 1'b1, '{ST_NOT_FOUND, 16'd0, 5'd0}},
		'{2'd1, 8'h78, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd1, 8'h41, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd1, 8'h42, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd1, 8'h43, 1'b0, 1'b1, '{ST_FOUND, 16'd1, 5'd3}},
		'{2'd1, 8'h41, 1'b1, 1'b0, NO_OUTCOME},
		'{2'd1, 8'h41, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd1, 8'h42, 1'b1, 1'b1, '{ST_TOO_LONG, 16'd0, 5'd0}},
		'{2'd2, 8'h00, 1'b1, 1'b1, '{ST_FOUND, 16'd0, 5'd1}},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b0, 1'b0, NO_OUTCOME},
		'{2'd3, 8'hFF, 1'b1, 1'b1, '{ST_FOUND, 16'd0, 5'd16}}
	};

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index    = REG_PAT_LO;
	logic [WORD_W-1:0]    cfg_data     = '0;
	logic                 text_valid   = 1'b0;
	logic                 text_stall;
	byte_t                text_byte    = '0;
	logic                 end_of_text  = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [INDEX_W-1:0]   match_index;
	len_t                 match_length;
	logic                 last;

	byte_t        recent [PATTERN_MAX];
	pos_t         text_pos;
	logic         reported;
	pattern_cfg_t active_cfg;

	outcome_t awaited_outcomes [$];
	int       mismatch_count = 0;
	bit       gaps_on        = 1'b1;

	substring_first_match dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4ms;
		$display("** substring_first_match: FAILED **");
		$finish;
	end

	function automatic byte_t pattern_at(input pattern_cfg_t cfg, input int k);
		return (k < 8) ? cfg.lo[8*k +: 8] : cfg.hi[8*(k-8) +: 8];
	endfunction

	function automatic void clear_text();
		foreach (recent[k]) recent[k] = '0;
		text_pos = '0;
		reported = 1'b0;
	endfunction

	function automatic logic scan_byte(input byte_t value, input logic eot, output outcome_t found);
		int   span;
		int   seen;
		logic hit;
		logic produced;
		span     = (int'(active_cfg.len) > PATTERN_MAX) ? PATTERN_MAX : int'(active_cfg.len);
		seen     = int'(text_pos) + 1;
		produced = 1'b0;
		found    = NO_OUTCOME;
		for (int k = PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
		recent[0] = value;
		if (!reported && span > 0 && seen >= span) begin
			hit = 1'b1;
			for (int k = 0; k < span; k++) begin
				if (pattern_at(active_cfg, k) != recent[span-1-k]) hit = 1'b0;
			end
			if (hit) begin
				found    = '{ST_FOUND, INDEX_W'(seen - span), len_t'(span)};
				reported = 1'b1;
				produced = 1'b1;
			end
		end
		if (eot) begin
			if (!reported) begin
				found    = '{(span > seen) ? ST_TOO_LONG : ST_NOT_FOUND, '0, '0};
				produced = 1'b1;
			end
			clear_text();
		end else if (text_pos != POS_MAX) begin
			text_pos++;
		end
		return produced;
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// A transfer takes place at the first rising edge with valid high and stall low.
	task automatic send_byte(input byte_t value, input logic eot, input logic typed = 1'b0,
			input outcome_t want = NO_OUTCOME);
		outcome_t predicted;
		logic     produced;
		while (gaps_on && $urandom_range(99) < 16) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= value;
		end_of_text <= eot;
		do @(posedge clk); while (text_stall);
		produced = scan_byte(value, eot, predicted);
		if (typed) awaited_outcomes.push_back(want);
		else if (produced) awaited_outcomes.push_back(predicted);
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		do @(posedge clk); while (awaited_outcomes.size() != 0);
	endtask

	task automatic load_pattern(input pattern_cfg_t cfg);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PAT_LO;
		cfg_data  <= cfg.lo;
		@(posedge clk);
		cfg_index <= REG_PAT_HI;
		cfg_data  <= cfg.hi;
		@(posedge clk);
		cfg_index <= REG_PAT_LEN;
		cfg_data  <= WORD_W'(cfg.len);
		@(posedge clk);
		cfg_we     <= 1'b0;
		active_cfg  = cfg;
	endtask

	always @(posedge clk) begin
		result_stall <= gaps_on && ($urandom_range(99) < 16);
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_outcomes.size() == 0) begin
				note_mismatch($sformatf("unexpected result: status %0d index %0d length %0d",
					status, match_index, match_length));
			end else begin
				want = awaited_outcomes.pop_front();
				if (status !== want.status)
					note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (match_index !== want.index)
					note_mismatch($sformatf("match_index %0d, expected %0d", match_index, want.index));
				if (match_length !== want.length)
					note_mismatch($sformatf("match_length %0d, expected %0d", match_length,
						want.length));
				if (last !== 1'b1)
					note_mismatch($sformatf("last %b, expected 1", last));
			end
		end
	end

	initial begin
		directed_step_t step;
		pattern_cfg_t   cfg;
		byte_t          alphabet [4];
		byte_t          text_q [$];
		byte_t          pick;
		int             span;
		int             eff;
		int             sym_count;
		int             text_len;
		int             spot;
		int             phase_bytes;
		clear_text();
		active_cfg = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			step = DIRECTED_STEPS[i];
			if (DIRECTED_CFG[step.setting] != active_cfg) load_pattern(DIRECTED_CFG[step.setting]);
			send_byte(step.value, step.eot, step.typed, step.want);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       span = 1;
				1:       span = 16;
				2:       span = 0;
				3:       span = 31;
				4:       span = 17;
				default: span = $urandom_range(2, 15);
			endcase
			eff       = (span > PATTERN_MAX) ? PATTERN_MAX : span;
			sym_count = $urandom_range(2, 4);
			foreach (alphabet[k]) alphabet[k] = byte_t'($urandom_range(255));
			cfg.len = len_t'(span);
			for (int k = 0; k < PATTERN_MAX; k++) begin
				pick = (k < eff) ? alphabet[$urandom_range(sym_count - 1)]
				                 : byte_t'($urandom_range(255));
				if (k < 8) cfg.lo[8*k +: 8] = pick;
				else cfg.hi[8*(k-8) +: 8] = pick;
			end
			gaps_on = 1'b1;
			load_pattern(cfg);
			gaps_on     = (phase != QUIET_PHASE);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				if (phase == PAUSE_PHASE) wait_drained();
				text_len = ($urandom_range(9) == 0) ? $urandom_range(1, (eff > 2) ? eff : 2)
				                                   : $urandom_range(1, 3 * eff + 12);
				text_q.delete();
				for (int k = 0; k < text_len; k++) begin
					text_q.push_back(($urandom_range(9) == 0) ? byte_t'($urandom_range(255))
					                                         : alphabet[$urandom_range(sym_count - 1)]);
				end
				if (eff > 0 && $urandom_range(3) != 0) begin
					spot = $urandom_range(text_len - 1);
					for (int k = 0; k < eff && spot + k < text_len; k++)
						text_q[spot + k] = pattern_at(cfg, k);
				end
				foreach (text_q[k]) send_byte(text_q[k], k == text_len - 1);
				phase_bytes += text_len;
			end
		end

		gaps_on = 1'b1;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** substring_first_match: PASSED **");
		end else begin
			$display("** substring_first_match: FAILED **");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/sfm_pkg.sv
rtl/sfm_cell.sv
rtl/substring_first_match.sv
dv/tb.sv
